// File: sv/rgbfb_pkg.sv
// rgbfb_pkg: shared types, constants and lookup functions for the RGB matrix
// duty framebuffer. No dependencies; imported by all modules but rgbfb_ram.
`timescale 1ns / 1ps

package rgbfb_pkg;

  // Matrix geometry
  localparam int COLUMNS   = 16;
  localparam int ROWS      = 6;
  localparam int ROW_CHANS = 3;
  localparam int CHANS     = ROWS * ROW_CHANS;     // duty entries per column
  localparam int DEPTH     = COLUMNS * CHANS;      // duty store entries
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int VROWS     = COLUMNS * ROWS;       // pixel rows with a valid bit
  localparam int VIDX_W    = $clog2(VROWS);

  // Intensity scaling: duty = (v * 75) >> 4
  localparam logic [6:0] SCALE_MUL   = 7'd75;
  localparam int         SCALE_SHIFT = 4;

  // Command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  // Configuration register indexes
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_INVERT = 1'b1;

  localparam logic [15:0] PERIOD_RST = 16'd1200;
  localparam logic        INVERT_RST = 1'b1;

  // Channel step counter
  localparam logic [4:0] LAST_CHAN = 5'(CHANS - 1);
  localparam logic [4:0] LAST_COLOR = 5'(ROW_CHANS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET,
    ST_LOAD
  } rgbfb_state_t;

  // Controller to datapath
  typedef struct packed {
    logic       capture;  // latch command fields
    logic       clear;    // drop all stored pixels, latch off duty
    logic       write;    // write one color of the latched pixel
    logic       read;     // read one channel of the latched column
    logic [4:0] step;     // color or channel index
  } rgbfb_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;
    logic set_ok;
    logic load_ok;
  } rgbfb_stat_t;

  // Scaled duty, optionally inverted against the period (wraps mod 2^16)
  function automatic logic [15:0] scale_duty(input logic [7:0] v,
                                             input logic [15:0] period,
                                             input logic inv);
    logic [14:0] prod;
    logic [15:0] s;
    prod = 15'(v) * 15'(SCALE_MUL);
    s    = 16'(prod >> SCALE_SHIFT);
    return inv ? (period - s) : s;
  endfunction

  // Pixel row that owns a channel index
  function automatic logic [2:0] chan_row(input logic [4:0] ch);
    logic [2:0] r;
    case (ch)
      5'd0, 5'd1, 5'd2:    r = 3'd0;
      5'd3, 5'd4, 5'd5:    r = 3'd1;
      5'd6, 5'd7, 5'd8:    r = 3'd2;
      5'd9, 5'd10, 5'd11:  r = 3'd3;
      5'd12, 5'd13, 5'd14: r = 3'd4;
      default:             r = 3'd5;
    endcase
    return r;
  endfunction

  // Factory channel order: group 2 pins 0-5, group 1 pins 0-5,
  // group 0 pins 3-5, group 0 pins 0-2
  function automatic logic [1:0] chan_group(input logic [4:0] ch);
    logic [1:0] g;
    if (ch < 5'd6)       g = 2'd2;
    else if (ch < 5'd12) g = 2'd1;
    else                 g = 2'd0;
    return g;
  endfunction

  function automatic logic [2:0] chan_pin(input logic [4:0] ch);
    logic [2:0] p;
    case (ch)
      5'd0, 5'd6, 5'd15:  p = 3'd0;
      5'd1, 5'd7, 5'd16:  p = 3'd1;
      5'd2, 5'd8, 5'd17:  p = 3'd2;
      5'd3, 5'd9, 5'd12:  p = 3'd3;
      5'd4, 5'd10, 5'd13: p = 3'd4;
      default:            p = 3'd5;
    endcase
    return p;
  endfunction

endpackage

// File: sv/rgb_matrix_duty_framebuffer_unit.sv
// rgb_matrix_duty_framebuffer_unit: top level of the RGB matrix duty framebuffer.
// Depends on rgbfb_pkg, rgbfb_ctrl, rgbfb_datapath (which holds rgbfb_ram).
`timescale 1ns / 1ps
//
// Channel   Handshake          Payload
// --------  -----------------  ----------------------------------------------
// command   start & !busy      command, row, column, red, green, blue
// result    valid (1 cycle)    pwm_group, pwm_pin, duty, last
// config    cfg_we             cfg_addr (0 period, 1 invert), cfg_wdata
//
// Clear does not raise busy: row valid bits drop at once, unwritten rows read as
// the latched off duty. Set holds busy for one store write per color, so a new
// set is taken only after its last write. Load holds busy for one store read
// per channel; results follow in the cycle after each read, one transfer per
// cycle, the last one in the idle cycle that takes the next command. A new load
// is therefore taken only after the last channel of the column has been read.
// Reset is synchronous; the store itself is not swept, the row valid bits
// stand in for it. The receiver cannot stall: each result shows for one cycle.

module rgb_matrix_duty_framebuffer_unit (
  input  logic        clk,
  input  logic        rst,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [2:0]  row,
  input  logic [4:0]  column,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  // results
  output logic        valid,
  output logic [1:0]  pwm_group,
  output logic [2:0]  pwm_pin,
  output logic [15:0] duty,
  output logic        last
);

  import rgbfb_pkg::*;

  rgbfb_ctrl_t ctrl;
  rgbfb_stat_t stat;

  rgbfb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  rgbfb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .command   (command),
    .row       (row),
    .column    (column),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .ctrl      (ctrl),
    .stat      (stat),
    .valid     (valid),
    .pwm_group (pwm_group),
    .pwm_pin   (pwm_pin),
    .duty      (duty),
    .last      (last)
  );

endmodule

// File: sv/rgbfb_ram.sv
// rgbfb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rgbfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 288
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/rgbfb_ctrl.sv
// rgbfb_ctrl: command sequencer. Steps set-pixel writes and column-load reads.
// Depends on rgbfb_pkg.
`timescale 1ns / 1ps

module rgbfb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  rgbfb_pkg::rgbfb_stat_t stat,
  output rgbfb_pkg::rgbfb_ctrl_t ctrl
);

  import rgbfb_pkg::*;

  rgbfb_state_t state, state_next;
  logic [4:0]   step, step_next;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    step_next    = step;
    ctrl         = '0;
    ctrl.step    = step;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        if (start) begin
          if (stat.is_clear) begin
            ctrl.clear = 1'b1;
          end else if (stat.set_ok) begin
            ctrl.capture = 1'b1;
            state_next   = ST_SET;
          end else if (stat.load_ok) begin
            ctrl.capture = 1'b1;
            state_next   = ST_LOAD;
          end
        end
      end
      ST_SET: begin
        ctrl.write = 1'b1;
        step_next  = step + 5'd1;
        if (step == LAST_COLOR) begin
          state_next = ST_IDLE;
          step_next  = '0;
        end
      end
      ST_LOAD: begin
        ctrl.read = 1'b1;
        step_next = step + 5'd1;
        if (step == LAST_CHAN) begin
          state_next = ST_IDLE;
          step_next  = '0;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Checks
  a_set_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_SET |-> step <= LAST_COLOR)
    else $error("set step out of range");

  a_load_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> step <= LAST_CHAN)
    else $error("load step out of range");

  a_load_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && step == LAST_CHAN) |=> state == ST_IDLE)
    else $error("load did not end after last channel");

endmodule

// File: sv/rgbfb_datapath.sv
// rgbfb_datapath: config registers, pixel latch, duty scaling, duty store
// with per-row valid bits, and result registers. Depends on rgbfb_pkg, rgbfb_ram.
`timescale 1ns / 1ps

module rgbfb_datapath (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [15:0]            cfg_wdata,
  // command fields
  input  logic [1:0]             command,
  input  logic [2:0]             row,
  input  logic [4:0]             column,
  input  logic [7:0]             red,
  input  logic [7:0]             green,
  input  logic [7:0]             blue,
  // control
  input  rgbfb_pkg::rgbfb_ctrl_t ctrl,
  output rgbfb_pkg::rgbfb_stat_t stat,
  // results
  output logic                   valid,
  output logic [1:0]             pwm_group,
  output logic [2:0]             pwm_pin,
  output logic [15:0]            duty,
  output logic                   last
);

  import rgbfb_pkg::*;

  logic [15:0]       pwm_period;
  logic              invert_duty;
  logic [15:0]       clear_duty;
  logic [VROWS-1:0]  row_valid;
  logic [2:0]        row_q;
  logic [4:0]        col_q;
  logic [7:0]        red_q, green_q, blue_q;
  logic              out_stb;
  logic [4:0]        out_idx;
  logic              rd_valid;

  logic [7:0]        color;
  logic [15:0]       wr_duty;
  logic [ADDR_W-1:0] col_base;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W-1:0] addr;
  logic [VIDX_W-1:0] vbase;
  logic [VIDX_W-1:0] set_vidx;
  logic [VIDX_W-1:0] rd_vidx;
  logic [15:0]       rdata;

  // Command decode for the sequencer
  always_comb begin
    stat.is_clear = (command == CMD_CLEAR);
    stat.set_ok   = (command == CMD_SET) && (row < 3'(ROWS))
                    && (6'(column) < 6'(COLUMNS));
    stat.load_ok  = (command == CMD_LOAD) && (6'(column) < 6'(COLUMNS));
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period  <= PERIOD_RST;
      invert_duty <= INVERT_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_PERIOD) begin
        pwm_period <= cfg_wdata;
      end else begin
        invert_duty <= cfg_wdata[0];
      end
    end
  end

  // Command field latch
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      row_q   <= row;
      col_q   <= column;
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
    end
  end

  // Color select and scaling for the current write
  always_comb begin
    case (ctrl.step[1:0])
      2'd0:    color = red_q;
      2'd1:    color = green_q;
      default: color = blue_q;
    endcase
  end

  assign wr_duty = scale_duty(color, pwm_period, invert_duty);

  // Store addressing: column base plus row/color or channel offset
  assign col_base = ADDR_W'(col_q) * ADDR_W'(CHANS);
  assign offset   = ctrl.write ? (ADDR_W'(row_q) * ADDR_W'(ROW_CHANS) + ADDR_W'(ctrl.step))
                               : ADDR_W'(ctrl.step);
  assign addr     = col_base + offset;

  assign vbase    = VIDX_W'(col_q) * VIDX_W'(ROWS);
  assign set_vidx = vbase + VIDX_W'(row_q);
  assign rd_vidx  = vbase + VIDX_W'(chan_row(ctrl.step));

  // Row valid bits: a row never set since reset or clear reads as clear_duty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      clear_duty <= '0;
    end else if (ctrl.clear) begin
      row_valid  <= '0;
      clear_duty <= invert_duty ? pwm_period : 16'd0;
    end else if (ctrl.write && ctrl.step == LAST_COLOR) begin
      row_valid[set_vidx] <= 1'b1;
    end
  end

  rgbfb_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctrl.write),
    .waddr (addr),
    .wdata (wr_duty),
    .re    (ctrl.read),
    .raddr (addr),
    .rdata (rdata)
  );

  // Result stage, aligned with the registered store read
  always_ff @(posedge clk) begin
    if (rst) begin
      out_stb <= 1'b0;
    end else begin
      out_stb <= ctrl.read;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.read) begin
      out_idx  <= ctrl.step;
      rd_valid <= row_valid[rd_vidx];
    end
  end

  assign valid     = out_stb;
  assign pwm_group = chan_group(out_idx);
  assign pwm_pin   = chan_pin(out_idx);
  assign duty      = rd_valid ? rdata : clear_duty;
  assign last      = (out_idx == LAST_CHAN);

  // Checks
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_stb |-> out_idx <= LAST_CHAN)
    else $error("result channel out of range");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_stb && out_idx == LAST_CHAN) |=> !out_stb)
    else $error("result transfer right after last of a column");

  a_rw_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.write && ctrl.read))
    else $error("store written and read in one cycle");

endmodule

// File: test/tb_rgb_matrix_duty_framebuffer_unit.sv
`timescale 1ns / 1ps
// tb_rgb_matrix_duty_framebuffer_unit: self-checking testbench for the RGB matrix duty framebuffer.
// Depends on rgbfb_pkg and rgb_matrix_duty_framebuffer_unit; reads no files.

module tb_rgb_matrix_duty_framebuffer_unit;
  import rgbfb_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;    // unused code, block must ignore it
  localparam int DUTY_GAIN  = 75;
  localparam int DUTY_SHIFT = 4;
  localparam int SETTLE     = 6;             // idle cycles before a register write
  localparam int TAIL       = 40;            // quiet cycles at the end for stray results
  localparam int QUIET_MAX  = 2000;          // watchdog limit, cycles with no transfer

  typedef enum logic [1:0] {
    JOB_CMD,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_t;

  typedef struct {
    job_kind_t   kind;
    int          idle_pct;
    logic [1:0]  command;
    logic [2:0]  row;
    logic [4:0]  column;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        cfg_addr;
    logic [15:0] cfg_data;
  } job_t;

  typedef struct {
    logic [1:0]  group;
    logic [2:0]  pin;
    logic [15:0] duty;
    logic        last;
  } duty_result_t;

  // DUT signals
  logic        clk;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        busy;
  logic [1:0]  command   = '0;
  logic [2:0]  row       = '0;
  logic [4:0]  column    = '0;
  logic [7:0]  red       = '0;
  logic [7:0]  green     = '0;
  logic [7:0]  blue      = '0;
  logic        cfg_we    = 1'b0;
  logic        cfg_addr  = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        valid;
  logic [1:0]  pwm_group;
  logic [2:0]  pwm_pin;
  logic [15:0] duty;
  logic        last;

  // Predictor state: shadow duty image plus configuration
  logic [15:0] duty_image [DEPTH];
  logic [15:0] period_cfg = PERIOD_RST;
  logic        invert_cfg = INVERT_RST;

  job_t         cmd_backlog [$];
  duty_result_t pending_duties [$];
  job_t         active_cmd;
  int           cur_idle;
  int           settle_left;
  int           errors;
  int           quiet_cycles;
  int           n_clear, n_set, n_load, n_ignored, n_cfg, n_results;

  rgb_matrix_duty_framebuffer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .row       (row),
    .column    (column),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .valid     (valid),
    .pwm_group (pwm_group),
    .pwm_pin   (pwm_pin),
    .duty      (duty),
    .last      (last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void report_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // Intensity to stored duty under the current configuration (wraps mod 2^16)
  function automatic logic [15:0] level_to_duty(input logic [7:0] v);
    logic [15:0] s;
    s = (16'(v) * 16'(DUTY_GAIN)) >> DUTY_SHIFT;
    return invert_cfg ? 16'(period_cfg - s) : s;
  endfunction

  // Update the shadow image for one accepted command; queue load readouts
  task automatic predict_command(input job_t j);
    int           base;
    duty_result_t r;
    case (j.command)
      CMD_CLEAR: begin
        foreach (duty_image[i]) duty_image[i] = level_to_duty(8'd0);
      end
      CMD_SET: begin
        if (j.row < ROWS && j.column < COLUMNS) begin
          base = j.column * CHANS + j.row * ROW_CHANS;
          duty_image[base]     = level_to_duty(j.red);
          duty_image[base + 1] = level_to_duty(j.green);
          duty_image[base + 2] = level_to_duty(j.blue);
        end
      end
      CMD_LOAD: begin
        if (j.column < COLUMNS) begin
          for (int ch = 0; ch < CHANS; ch++) begin
            // group 2 pins 0-5, group 1 pins 0-5, group 0 pins 3-5, group 0 pins 0-2
            r.group = (ch < 6) ? 2'd2 : (ch < 12) ? 2'd1 : 2'd0;
            r.pin   = (ch < 12) ? 3'(ch % 6) : (ch < 15) ? 3'(ch - 9) : 3'(ch - 15);
            r.duty  = duty_image[j.column * CHANS + ch];
            r.last  = (ch == CHANS - 1);
            pending_duties.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Stimulus builders
  task automatic add_cmd(input logic [1:0] c, input logic [2:0] rw, input logic [4:0] col,
                         input logic [7:0] rd, input logic [7:0] gn, input logic [7:0] bl);
    job_t j;
    j = '{kind: JOB_CMD, idle_pct: cur_idle, command: c, row: rw, column: col,
          red: rd, green: gn, blue: bl, cfg_addr: 1'b0, cfg_data: '0};
    cmd_backlog.push_back(j);
  endtask

  task automatic add_drain();
    job_t j;
    j = '{kind: JOB_DRAIN, idle_pct: 0, command: CMD_NONE, row: '0, column: '0,
          red: '0, green: '0, blue: '0, cfg_addr: 1'b0, cfg_data: '0};
    cmd_backlog.push_back(j);
  endtask

  // Register writes only go out once the block has gone idle
  task automatic add_cfg(input logic a, input logic [15:0] d);
    job_t j;
    add_drain();
    j = '{kind: JOB_CFG, idle_pct: 0, command: CMD_NONE, row: '0, column: '0,
          red: '0, green: '0, blue: '0, cfg_addr: a, cfg_data: d};
    cmd_backlog.push_back(j);
  endtask

  function automatic logic [7:0] pick_level();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return 8'd0;
    if (p < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [4:0] pick_column();
    if ($urandom_range(0, 99) < 8) return 5'($urandom_range(COLUMNS, 31));
    return 5'($urandom_range(0, COLUMNS - 1));
  endfunction

  // Mostly in-range sets and loads; rare clears, stray codes, bad addresses
  task automatic add_random(input int count);
    int          p;
    logic [1:0]  c;
    logic [2:0]  rw;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      if (p < 3)       c = CMD_CLEAR;
      else if (p < 5)  c = CMD_NONE;
      else if (p < 60) c = CMD_SET;
      else             c = CMD_LOAD;
      if (c == CMD_SET && $urandom_range(0, 99) < 90) rw = 3'($urandom_range(0, ROWS - 1));
      else rw = 3'($urandom_range(0, 7));
      add_cmd(c, rw, pick_column(), pick_level(), pick_level(), pick_level());
    end
  endtask

  // Driver: one command transfer or register write at a time from the backlog
  always @(posedge clk) begin
    logic go;
    logic we;
    job_t j;
    if (rst) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      go = start;
      we = 1'b0;
      if (start && !busy) begin
        case (active_cmd.command)
          CMD_CLEAR: n_clear++;
          CMD_SET:   n_set++;
          CMD_LOAD:  n_load++;
          default:   n_ignored++;
        endcase
        predict_command(active_cmd);
        go = 1'b0;
      end
      if (!go) begin
        if (settle_left > 0) begin
          settle_left--;
        end else if (cmd_backlog.size() > 0) begin
          j = cmd_backlog[0];
          case (j.kind)
            JOB_DRAIN: begin
              if (pending_duties.size() == 0 && !busy) begin
                settle_left = SETTLE;
                void'(cmd_backlog.pop_front());
              end
            end
            JOB_CFG: begin
              we = 1'b1;
              cfg_addr  <= j.cfg_addr;
              cfg_wdata <= j.cfg_data;
              if (j.cfg_addr == REG_PERIOD) period_cfg = j.cfg_data;
              else invert_cfg = j.cfg_data[0];
              n_cfg++;
              void'(cmd_backlog.pop_front());
            end
            default: begin
              if ($urandom_range(0, 99) >= j.idle_pct) begin
                go = 1'b1;
                active_cmd = j;
                command <= j.command;
                row     <= j.row;
                column  <= j.column;
                red     <= j.red;
                green   <= j.green;
                blue    <= j.blue;
                void'(cmd_backlog.pop_front());
              end
            end
          endcase
        end
      end
      start  <= go;
      cfg_we <= we;
    end
  end

  // Monitor: each strobed result against the oldest expected readout
  always @(posedge clk) begin
    duty_result_t want;
    if (!rst && valid) begin
      n_results++;
      if (pending_duties.size() == 0) begin
        report_error($sformatf("unexpected result: group %0d pin %0d duty %0d last %0b",
                               pwm_group, pwm_pin, duty, last));
      end else begin
        want = pending_duties.pop_front();
        if (pwm_group !== want.group || pwm_pin !== want.pin ||
            duty !== want.duty || last !== want.last)
          report_error($sformatf(
            "expected group %0d pin %0d duty %0d last %0b, got group %0d pin %0d duty %0d last %0b",
            want.group, want.pin, want.duty, want.last, pwm_group, pwm_pin, duty, last));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("Watchdog: no transfer for %0d cycles", QUIET_MAX);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    foreach (duty_image[i]) duty_image[i] = '0;

    // Directed: reset contents, extremes, ignored addresses and codes
    cur_idle = 17;
    add_cmd(CMD_LOAD, 3'd0, 5'd0, 8'd0, 8'd0, 8'd0);
    add_cmd(CMD_SET, 3'd0, 5'd0, 8'd0, 8'hFF, 8'h80);
    add_cmd(CMD_SET, 3'd5, 5'(COLUMNS - 1), 8'hFF, 8'hFF, 8'hFF);
    add_cmd(CMD_SET, 3'd3, 5'd7, 8'h55, 8'hAA, 8'h01);
    add_cmd(CMD_SET, 3'd6, 5'd2, 8'h11, 8'h22, 8'h33);
    add_cmd(CMD_SET, 3'd7, 5'd31, 8'h44, 8'h55, 8'h66);
    add_cmd(CMD_SET, 3'd1, 5'(COLUMNS), 8'h77, 8'h88, 8'h99);
    add_cmd(CMD_NONE, 3'd2, 5'd2, 8'hFF, 8'hFF, 8'hFF);
    add_cmd(CMD_LOAD, 3'd0, 5'd0, 8'd0, 8'd0, 8'd0);
    add_cmd(CMD_LOAD, 3'd0, 5'(COLUMNS - 1), 8'd0, 8'd0, 8'd0);
    add_cmd(CMD_LOAD, 3'd7, 5'd7, 8'hFF, 8'hFF, 8'hFF);
    add_cmd(CMD_LOAD, 3'd0, 5'(COLUMNS), 8'd0, 8'd0, 8'd0);
    add_cmd(CMD_LOAD, 3'd0, 5'd31, 8'd0, 8'd0, 8'd0);
    add_cmd(CMD_CLEAR, 3'd7, 5'd31, 8'hFF, 8'hFF, 8'hFF);
    add_cmd(CMD_LOAD, 3'd0, 5'd7, 8'd0, 8'd0, 8'd0);
    add_drain();
    // Period under the scaled intensity: inverted duty wraps
    add_cfg(REG_PERIOD, 16'd300);
    add_cmd(CMD_SET, 3'd2, 5'd4, 8'hFF, 8'd0, 8'd64);
    add_cmd(CMD_LOAD, 3'd0, 5'd4, 8'd0, 8'd0, 8'd0);
    // Stored values survive a config change
    add_cfg(REG_INVERT, 16'd0);
    add_cmd(CMD_SET, 3'd4, 5'd4, 8'hFF, 8'd1, 8'd16);
    add_cmd(CMD_LOAD, 3'd0, 5'd4, 8'd0, 8'd0, 8'd0);
    add_cmd(CMD_CLEAR, 3'd0, 5'd0, 8'd0, 8'd0, 8'd0);
    add_cmd(CMD_LOAD, 3'd0, 5'd0, 8'd0, 8'd0, 8'd0);

    // Random phases across configurations and sender idling
    add_cfg(REG_PERIOD, 16'd1195);
    add_cfg(REG_INVERT, 16'd1);
    add_random(40);
    add_cfg(REG_PERIOD, 16'hFFFF);
    cur_idle = 52;
    add_random(25);
    add_drain();
    add_random(20);
    add_cfg(REG_INVERT, 16'd0);
    add_cfg(REG_PERIOD, 16'd40000);
    cur_idle = 0;
    add_random(30);
    add_cfg(REG_INVERT, 16'd1);
    add_cfg(REG_PERIOD, PERIOD_RST);
    add_random(25);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() > 0 || start || pending_duties.size() > 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Run: %0d set, %0d load, %0d clear, %0d ignored-code transfers, %0d register writes",
             n_set, n_load, n_clear, n_ignored, n_cfg);
    $display("Duty results checked: %0d, mismatches: %0d", n_results, errors);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
sv/rgbfb_pkg.sv
sv/rgbfb_ram.sv
sv/rgbfb_ctrl.sv
sv/rgbfb_datapath.sv
sv/rgb_matrix_duty_framebuffer_unit.sv
test/tb_rgb_matrix_duty_framebuffer_unit.sv
